FILE: hdl/vfc_pkg.sv
// ============================================================================
// vfc_pkg
// Shared types, codes and defaults for the voxel face culling block.
// ============================================================================
`default_nettype none

package vfc_pkg;

    // Field widths
    localparam int COORD_W = 4;
    localparam int CODE_W  = 4;
    localparam int DIR_W   = 3;
    localparam int MAT_W   = 4;
    localparam int MCNT_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    // Default grid size
    localparam int GRID_X_DEF = 16;
    localparam int GRID_Y_DEF = 16;
    localparam int GRID_Z_DEF = 16;

    // Offset select for the neighbor unit; the first six are face directions
    localparam logic [DIR_W-1:0] DIR_FWD    = 3'd0;  // +x
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd1;  // +y
    localparam logic [DIR_W-1:0] DIR_BACK   = 3'd2;  // -x
    localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd3;  // -y
    localparam logic [DIR_W-1:0] DIR_UP     = 3'd4;  // +z
    localparam logic [DIR_W-1:0] DIR_DOWN   = 3'd5;  // -z
    localparam logic [DIR_W-1:0] DIR_CENTER = 3'd6;  // the voxel itself

    // Request kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SCAN  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AIR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRUNK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MCNT  = 2'd3;

    // Configuration reset values
    localparam logic [CODE_W-1:0] AIR_RST   = 4'd0;
    localparam logic [CODE_W-1:0] WATER_RST = 4'd1;
    localparam logic [CODE_W-1:0] TRUNK_RST = 4'd6;
    localparam logic [MCNT_W-1:0] MCNT_RST  = 5'd12;

    // Block codes below this carry no material of their own
    localparam logic [CODE_W-1:0] MAT_OFFSET = 4'd2;

    // Result of one neighbor lookup
    typedef struct packed {
        logic in_grid;
    } vfc_nbr_flags_t;

endpackage : vfc_pkg

`default_nettype wire

FILE: hdl/vfc_voxel_ram.sv
// ============================================================================
// vfc_voxel_ram
// Voxel code store: one write port and one registered read port.
// ============================================================================
`default_nettype none

module vfc_voxel_ram
    import vfc_pkg::*;
#(
    parameter int DEPTH = GRID_X_DEF * GRID_Y_DEF * GRID_Z_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [CODE_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [CODE_W-1:0] rd_data
);

    logic [CODE_W-1:0] mem [DEPTH];

    // Store a code
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read with registered data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : vfc_voxel_ram

`default_nettype wire

FILE: hdl/vfc_nbr_unit.sv
// ============================================================================
// vfc_nbr_unit
// Shared neighbor unit: offsets a position by one step (or not, for the center
// select), checks the grid bounds and forms the linear store address.
// ============================================================================
`default_nettype none

module vfc_nbr_unit
    import vfc_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF,
    parameter int AW     = $clog2(GRID_X * GRID_Y * GRID_Z)
) (
    input  wire logic [COORD_W-1:0] pos_x,
    input  wire logic [COORD_W-1:0] pos_y,
    input  wire logic [COORD_W-1:0] pos_z,
    input  wire logic [DIR_W-1:0]   dir,
    output vfc_nbr_flags_t          flags,
    output logic      [AW-1:0]      addr
);

    logic [COORD_W:0] nx;
    logic [COORD_W:0] ny;
    logic [COORD_W:0] nz;
    logic             under;
    logic [31:0]      lin;

    // Step one cell in the selected direction, flag a step below zero
    always_comb begin
        nx    = {1'b0, pos_x};
        ny    = {1'b0, pos_y};
        nz    = {1'b0, pos_z};
        under = 1'b0;
        unique case (dir)
            DIR_FWD:   nx = {1'b0, pos_x} + 1'b1;
            DIR_RIGHT: ny = {1'b0, pos_y} + 1'b1;
            DIR_BACK: begin
                nx    = {1'b0, pos_x} - 1'b1;
                under = (pos_x == '0);
            end
            DIR_LEFT: begin
                ny    = {1'b0, pos_y} - 1'b1;
                under = (pos_y == '0);
            end
            DIR_UP:    nz = {1'b0, pos_z} + 1'b1;
            DIR_DOWN: begin
                nz    = {1'b0, pos_z} - 1'b1;
                under = (pos_z == '0);
            end
            default: begin
            end
        endcase
    end

    // Bounds check and z-major linear address
    always_comb begin
        flags.in_grid = !under && (32'(nx) < GRID_X) && (32'(ny) < GRID_Y)
                        && (32'(nz) < GRID_Z);
        lin  = 32'(nz) * 32'(GRID_X * GRID_Y) + 32'(ny) * 32'(GRID_X) + 32'(nx);
        addr = lin[AW-1:0];
    end

endmodule : vfc_nbr_unit

`default_nettype wire

FILE: hdl/voxel_face_culling.sv
// ============================================================================
// voxel_face_culling
// Culled voxel face generator over a grid of 4-bit block codes.
// ============================================================================
// Usage:
//   s_* carries requests: s_tuser is the kind (0 write, 1 scan), s_tdata the
//   position and the block code. A write stores the code; a scan emits one
//   face request on m_* for each visible side of a solid voxel (each side for a
//   trunk voxel), in the order +x, +y, -x, -y, +z, -z, with m_tlast on the final face.
//   cfg_* writes the air, water and trunk codes and the material count;
//   write it only while no request is in flight.
// Timing:
//   A scan makes at most one memory read per cycle through one shared address
//   unit (voxel, then each of the six neighbors that lies in the grid); the
//   next request is taken only after its last face, if any, is loaded into the
//   output register, and an air voxel ends the scan after the voxel read.
//   s_tready is high only between requests.
// Reset:
//   aresetn (synchronous, active low) clears the sequencer, the output valid
//   and the configuration registers; the voxel store is not cleared, and a
//   cell must be written before it is scanned or read as a neighbor.
// Stall:
//   Faces leave through an output register; while m_tready is low it holds
//   and the sequencer waits before loading the next face.
// ============================================================================
`default_nettype none

module voxel_face_culling
    import vfc_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,  // pos_x, pos_y, pos_z, block_code
    input  wire logic                 s_tuser,  // action
    // Face channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [23:0]          m_tdata,  // face_x, face_y, face_z, direction,
                                                // material, zero pad
    output logic                      m_tlast,  // last_face
    // Configuration channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_CENTER = 5'b00100,
        ST_NBR    = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [CODE_W-1:0] air_reg, water_reg, trunk_reg;
    logic [MCNT_W-1:0] mcnt_reg;

    // Captured request
    logic               act_reg;
    logic [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [CODE_W-1:0]  code_reg;

    // Scan state
    logic [DIR_W-1:0] dir_reg, dir_next;
    logic             inb_reg, inb_next;
    logic [5:0]       vis_reg, vis_next;
    logic [MAT_W-1:0] mat_reg, mat_next;
    logic             allf_reg, allf_next;

    // Output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [DIR_W-1:0]   odir_reg, odir_next;
    logic               olast_reg, olast_next;
    logic [COORD_W-1:0] ox_reg, ox_next;
    logic [COORD_W-1:0] oy_reg, oy_next;
    logic [COORD_W-1:0] oz_reg, oz_next;
    logic [MAT_W-1:0]   omat_reg, omat_next;
    logic               load_out;

    // Shared unit and memory
    logic [DIR_W-1:0] unit_dir;
    vfc_nbr_flags_t   unit_flags;
    logic [AW-1:0]    unit_addr;
    logic             wr_en, rd_en;
    logic [CODE_W-1:0] rd_data;

    // Material and face pick
    logic [CODE_W-1:0] mat_raw;
    logic [MCNT_W-1:0] max_mat;
    logic [MAT_W-1:0]  mat_calc;
    logic              see;
    logic [DIR_W-1:0]  pick_dir;
    logic [5:0]        pick_mask;
    logic [5:0]        rest_mask;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Capture the request
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg  <= s_tuser;
            x_reg    <= s_tdata[3:0];
            y_reg    <= s_tdata[7:4];
            z_reg    <= s_tdata[11:8];
            code_reg <= s_tdata[15:12];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            air_reg   <= AIR_RST;
            water_reg <= WATER_RST;
            trunk_reg <= TRUNK_RST;
            mcnt_reg  <= MCNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_AIR:   air_reg   <= cfg_data[CODE_W-1:0];
                CFG_WATER: water_reg <= cfg_data[CODE_W-1:0];
                CFG_TRUNK: trunk_reg <= cfg_data[CODE_W-1:0];
                CFG_MCNT:  mcnt_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Select the offset for the shared unit
    always_comb begin
        priority if (state_reg == ST_CENTER) begin
            unit_dir = DIR_FWD;
        end else if (state_reg == ST_NBR) begin
            unit_dir = dir_reg + 1'b1;
        end else begin
            unit_dir = DIR_CENTER;
        end
    end

    vfc_nbr_unit #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z),
        .AW     (AW)
    ) u_nbr (
        .pos_x  (x_reg),
        .pos_y  (y_reg),
        .pos_z  (z_reg),
        .dir    (unit_dir),
        .flags  (unit_flags),
        .addr   (unit_addr)
    );

    vfc_voxel_ram #(
        .DEPTH   (DEPTH),
        .AW      (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (unit_addr),
        .wr_data (code_reg),
        .rd_en   (rd_en),
        .rd_addr (unit_addr),
        .rd_data (rd_data)
    );

    // Clamp code minus two into the material range
    always_comb begin
        mat_raw = (rd_data < MAT_OFFSET) ? '0 : rd_data - MAT_OFFSET;
        max_mat = (mcnt_reg == '0) ? '0 : mcnt_reg - 1'b1;
        if ({1'b0, mat_raw} > max_mat) begin
            mat_calc = max_mat[MAT_W-1:0];
        end else begin
            mat_calc = mat_raw;
        end
    end

    // Neighbor is see-through when outside the grid, air or water, or for a trunk voxel
    assign see = allf_reg || !inb_reg || (rd_data == air_reg) || (rd_data == water_reg);

    // Pick the lowest pending face
    always_comb begin
        pick_dir  = DIR_FWD;
        pick_mask = '0;
        for (int i = 5; i >= 0; i--) begin
            if (vis_reg[i]) begin
                pick_dir  = DIR_W'(i);
                pick_mask = 6'(1) << i;
            end
        end
        rest_mask = vis_reg & ~pick_mask;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        dir_next   = dir_reg;
        inb_next   = inb_reg;
        vis_next   = vis_reg;
        mat_next   = mat_reg;
        allf_next  = allf_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!unit_flags.in_grid) begin
                    state_next = ST_IDLE;
                end else if (act_reg == ACT_WRITE) begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER: begin
                if (rd_data == air_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    mat_next   = mat_calc;
                    allf_next  = (trunk_reg >= MAT_OFFSET)
                                 && (mat_calc == trunk_reg - MAT_OFFSET);
                    rd_en      = unit_flags.in_grid;
                    inb_next   = unit_flags.in_grid;
                    dir_next   = DIR_FWD;
                    vis_next   = '0;
                    state_next = ST_NBR;
                end
            end
            ST_NBR: begin
                vis_next[dir_reg] = see;
                if (dir_reg == DIR_DOWN) begin
                    state_next = ST_EMIT;
                end else begin
                    rd_en    = unit_flags.in_grid;
                    inb_next = unit_flags.in_grid;
                    dir_next = dir_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (vis_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (!m_tvalid_reg || m_tready) begin
                    load_out = 1'b1;
                    vis_next = rest_mask;
                    if (rest_mask == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register next values
    always_comb begin
        odir_next  = odir_reg;
        olast_next = olast_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        omat_next  = omat_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            odir_next     = pick_dir;
            olast_next    = (rest_mask == '0);
            ox_next       = x_reg;
            oy_next       = y_reg;
            oz_next       = z_reg;
            omat_next     = mat_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Scan and output payload
    always_ff @(posedge aclk) begin
        dir_reg   <= dir_next;
        inb_reg   <= inb_next;
        vis_reg   <= vis_next;
        mat_reg   <= mat_next;
        allf_reg  <= allf_next;
        odir_reg  <= odir_next;
        olast_reg <= olast_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        omat_reg  <= omat_next;
    end

    // Face request from the output register
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {5'b0, omat_reg, odir_reg, oz_reg, oy_reg, ox_reg};

endmodule : voxel_face_culling

`default_nettype wire

FILE: sim/tb_voxel_face_culling.sv
// ============================================================================
// tb_voxel_face_culling
// Self-checking testbench for the voxel face culling block.
// ============================================================================
// Drives write and scan requests into the block and keeps its own copy of
// the voxel grid and configuration registers. Every accepted scan is expanded
// into the faces it should produce, and each face that leaves the block is
// checked against the oldest outstanding face. Neighbor cells are always
// written before a scan, so no cell is ever read before its first write.
// Covered: directed corner, trunk, buried, air and water cases; extreme
// register settings; output backpressure that fills the block; and random
// clustered traffic under three idle patterns.
// ============================================================================
`default_nettype none

module tb_voxel_face_culling
    import vfc_pkg::*;
();

    localparam int CELL_COUNT    = GRID_X_DEF * GRID_Y_DEF * GRID_Z_DEF;
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 35;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [DIR_W-1:0]   dir;
        logic [MAT_W-1:0]   mat;
        logic               last;
    } face_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;   // pos_x, pos_y, pos_z, block_code
    logic                 s_tuser;   // action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // face_x, face_y, face_z, direction, material, pad
    logic                 m_tlast;   // last_face
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Shadow grid and registers
    logic [CODE_W-1:0] vox_mem [CELL_COUNT];
    bit                vox_written [CELL_COUNT];
    logic [CODE_W-1:0] air_reg;
    logic [CODE_W-1:0] water_reg;
    logic [CODE_W-1:0] trunk_reg;
    logic [MCNT_W-1:0] mcnt_reg;

    face_t face_queue [$];
    int    mismatch_count = 0;
    int    items_sent = 0;
    int    quiet_cycles = 0;
    int    src_idle_pct;
    int    snk_idle_pct;
    logic  sink_hold;

    voxel_face_culling dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Grid helpers
    // ------------------------------------------------------------------------
    function automatic int cell_at(input int x, input int y, input int z);
        return z * GRID_X_DEF * GRID_Y_DEF + y * GRID_X_DEF + x;
    endfunction

    function automatic bit in_grid(input int x, input int y, input int z);
        return x >= 0 && x < GRID_X_DEF && y >= 0 && y < GRID_Y_DEF &&
               z >= 0 && z < GRID_Z_DEF;
    endfunction

    // Step one cell in a face direction; any other code stays on the voxel
    function automatic void neighbor_of(input logic [DIR_W-1:0] d, input int x,
                                        input int y, input int z,
                                        output int nx, output int ny, output int nz);
        nx = x;
        ny = y;
        nz = z;
        case (d)
            DIR_FWD:   nx = x + 1;
            DIR_RIGHT: ny = y + 1;
            DIR_BACK:  nx = x - 1;
            DIR_LEFT:  ny = y - 1;
            DIR_UP:    nz = z + 1;
            DIR_DOWN:  nz = z - 1;
            default:   ;
        endcase
    endfunction

    function automatic bit see_through(input int x, input int y, input int z);
        logic [CODE_W-1:0] c;
        if (!in_grid(x, y, z))
            return 1'b1;
        c = vox_mem[cell_at(x, y, z)];
        return c == air_reg || c == water_reg;
    endfunction

    // Bias codes toward the configured special ones
    function automatic logic [CODE_W-1:0] pick_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return air_reg;
        if (roll < 40)
            return water_reg;
        if (roll < 55)
            return trunk_reg;
        return CODE_W'($urandom_range(0, 15));
    endfunction

    // Expand one scan into the faces it should produce
    task automatic predict_faces(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                 input logic [COORD_W-1:0] z);
        logic [CODE_W-1:0] code;
        int                mat;
        int                max_mat;
        int                nx, ny, nz;
        int                n;
        bit                all_sides;
        face_t             faces [6];
        code = vox_mem[cell_at(x, y, z)];
        n = 0;
        if (code == air_reg)
            return;
        mat = int'(code) - int'(MAT_OFFSET);
        max_mat = (mcnt_reg == 0) ? 0 : int'(mcnt_reg) - 1;
        if (mat < 0)
            mat = 0;
        if (mat > max_mat)
            mat = max_mat;
        all_sides = (mat == int'(trunk_reg) - int'(MAT_OFFSET));
        for (int i = 0; i < 6; i++) begin
            neighbor_of(DIR_W'(i), x, y, z, nx, ny, nz);
            if (all_sides || see_through(nx, ny, nz)) begin
                faces[n] = '{x: x, y: y, z: z, dir: DIR_W'(i), mat: MAT_W'(mat), last: 1'b0};
                n++;
            end
        end
        if (n > 0)
            faces[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            face_queue.push_back(faces[i]);
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_request(input logic act, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                                input logic [CODE_W-1:0] code);
        // Idle the request channel at random before offering
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {code, z, y, x};
        do
            @(posedge aclk);
        while (s_tready !== 1'b1);
        items_sent++;
        if (act == ACT_WRITE) begin
            vox_mem[cell_at(x, y, z)] = code;
            vox_written[cell_at(x, y, z)] = 1'b1;
        end else begin
            predict_faces(x, y, z);
        end
    endtask

    // Write any unwritten cell around the voxel or at it, then scan it
    task automatic scan_cell(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z);
        int nx, ny, nz;
        // The seventh step lands on the voxel itself
        for (int i = 0; i <= 6; i++) begin
            neighbor_of(DIR_W'(i), x, y, z, nx, ny, nz);
            if (in_grid(nx, ny, nz) && !vox_written[cell_at(nx, ny, nz)])
                send_request(ACT_WRITE, nx[3:0], ny[3:0], nz[3:0], pick_code());
        end
        send_request(ACT_SCAN, x, y, z, CODE_W'($urandom_range(0, 15)));
    endtask

    // Drop valid, drain all faces, then give in-flight work time to finish
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (face_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_registers(input logic [CODE_W-1:0] air,
                                     input logic [CODE_W-1:0] water,
                                     input logic [CODE_W-1:0] trunk,
                                     input logic [MCNT_W-1:0] count);
        logic [CFG_IDX_W-1:0] sel;
        for (int i = 0; i < 4; i++) begin
            sel = CFG_IDX_W'(i);
            cfg_valid <= 1'b1;
            cfg_index <= sel;
            case (sel)
                CFG_AIR:   cfg_data <= CFG_DAT_W'(air);
                CFG_WATER: cfg_data <= CFG_DAT_W'(water);
                CFG_TRUNK: cfg_data <= CFG_DAT_W'(trunk);
                CFG_MCNT:  cfg_data <= CFG_DAT_W'(count);
                default:   cfg_data <= '0;
            endcase
            do
                @(posedge aclk);
            while (cfg_ready !== 1'b1);
        end
        cfg_valid <= 1'b0;
        air_reg   = air;
        water_reg = water;
        trunk_reg = trunk;
        mcnt_reg  = count;
    endtask

    task automatic hold_sink(input int cycles);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge aclk);
        sink_hold <= 1'b0;
    endtask

    // Clustered traffic: mostly dense neighborhoods, some strays anywhere
    task automatic random_burst(input int count);
        int                 start;
        int                 roll;
        logic [COORD_W-1:0] bx, by, bz, px, py, pz;
        start = items_sent;
        bx = COORD_W'($urandom_range(0, 15));
        by = COORD_W'($urandom_range(0, 15));
        bz = COORD_W'($urandom_range(0, 15));
        while (items_sent - start < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                bx = COORD_W'($urandom_range(0, 15));
                by = COORD_W'($urandom_range(0, 15));
                bz = COORD_W'($urandom_range(0, 15));
            end
            px = bx + COORD_W'($urandom_range(0, 3));
            py = by + COORD_W'($urandom_range(0, 3));
            pz = bz + COORD_W'($urandom_range(0, 3));
            if (roll >= 90) begin
                px = COORD_W'($urandom_range(0, 15));
                py = COORD_W'($urandom_range(0, 15));
                pz = COORD_W'($urandom_range(0, 15));
            end
            if ($urandom_range(0, 99) < 40)
                send_request(ACT_WRITE, px, py, pz, pick_code());
            else
                scan_cell(px, py, pz);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_defaults();
        int nx, ny, nz;
        // Low corner: air ahead, water to the right, solid above, grid edge elsewhere
        send_request(ACT_WRITE, 4'd1, 4'd0, 4'd0, AIR_RST);
        send_request(ACT_WRITE, 4'd0, 4'd1, 4'd0, WATER_RST);
        send_request(ACT_WRITE, 4'd0, 4'd0, 4'd1, 4'd3);
        send_request(ACT_WRITE, 4'd0, 4'd0, 4'd0, 4'd15);
        scan_cell(4'd0, 4'd0, 4'd0);
        // High corner trunk, buried on its in-grid sides: still all six faces
        send_request(ACT_WRITE, 4'd14, 4'd15, 4'd15, 4'd2);
        send_request(ACT_WRITE, 4'd15, 4'd14, 4'd15, 4'd2);
        send_request(ACT_WRITE, 4'd15, 4'd15, 4'd14, 4'd2);
        send_request(ACT_WRITE, 4'd15, 4'd15, 4'd15, TRUNK_RST);
        scan_cell(4'd15, 4'd15, 4'd15);
        // Interior voxel fully enclosed by solid: no faces
        for (int i = 0; i < 6; i++) begin
            neighbor_of(DIR_W'(i), 8, 8, 8, nx, ny, nz);
            send_request(ACT_WRITE, nx[3:0], ny[3:0], nz[3:0], 4'd9);
        end
        send_request(ACT_WRITE, 4'd8, 4'd8, 4'd8, 4'd4);
        scan_cell(4'd8, 4'd8, 4'd8);
        // Air voxel and water voxel
        scan_cell(4'd1, 4'd0, 4'd0);
        scan_cell(4'd0, 4'd1, 4'd0);
        // Enclosed voxel turned trunk
        send_request(ACT_WRITE, 4'd8, 4'd8, 4'd8, TRUNK_RST);
        scan_cell(4'd8, 4'd8, 4'd8);
    endtask

    task automatic test_output_backpressure();
        logic [CODE_W-1:0] solid;
        settle_block();
        solid = air_reg + 4'd1;
        send_request(ACT_WRITE, 4'd0, 4'd0, 4'd0, solid);
        // Hold the face channel while scans keep arriving
        fork
            hold_sink(HOLD_CYCLES);
        join_none
        repeat (6) scan_cell(4'd0, 4'd0, 4'd0);
    endtask

    task automatic test_extreme_registers();
        // Top air code, water zero, trunk below two, zero material count
        settle_block();
        program_registers(4'd15, 4'd0, 4'd0, 5'd0);
        random_burst(20);
        // Top trunk code and a material count of 16
        settle_block();
        program_registers(4'd0, 4'd15, 4'd15, 5'd16);
        random_burst(20);
        // Air and water share a code; trunk matches material zero; one material
        settle_block();
        program_registers(4'd7, 4'd7, MAT_OFFSET, 5'd1);
        random_burst(20);
    endtask

    task automatic test_random_traffic();
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0:       begin src_idle_pct = 20; snk_idle_pct = 53; end
                1:       begin src_idle_pct = 53; snk_idle_pct = 20; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                settle_block();
                program_registers(CODE_W'($urandom_range(0, 15)),
                                  CODE_W'($urandom_range(0, 15)),
                                  CODE_W'($urandom_range(0, 15)),
                                  MCNT_W'($urandom_range(0, 16)));
                random_burst(PHASE_ITEMS);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Face channel: random ready, long hold on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || sink_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Check each accepted face against the oldest outstanding one
    always @(posedge aclk) begin
        face_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (face_queue.size() == 0) begin
                report_mismatch($sformatf("face with none outstanding: tdata %h tlast %b",
                                          m_tdata, m_tlast));
            end else begin
                want = face_queue.pop_front();
                if (m_tdata[3:0] !== want.x || m_tdata[7:4] !== want.y ||
                    m_tdata[11:8] !== want.z || m_tdata[14:12] !== want.dir ||
                    m_tdata[18:15] !== want.mat || m_tdata[23:19] !== 5'd0 ||
                    m_tlast !== want.last) begin
                    report_mismatch($sformatf(
                        {"got x%0d y%0d z%0d dir%0d mat%0d pad%h last%b, ",
                         "want x%0d y%0d z%0d dir%0d mat%0d last%b"},
                        m_tdata[3:0], m_tdata[7:4], m_tdata[11:8], m_tdata[14:12],
                        m_tdata[18:15], m_tdata[23:19], m_tlast,
                        want.x, want.y, want.z, want.dir, want.mat, want.last));
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[voxel_face_culling] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = ACT_WRITE;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_AIR;
        cfg_data  = '0;
        sink_hold = 1'b0;
        air_reg   = AIR_RST;
        water_reg = WATER_RST;
        trunk_reg = TRUNK_RST;
        mcnt_reg  = MCNT_RST;
        src_idle_pct = 20;
        snk_idle_pct = 53;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_defaults();
        test_output_backpressure();
        test_extreme_registers();
        test_random_traffic();
        settle_block();

        if (mismatch_count == 0)
            $display("[voxel_face_culling] OK");
        else
            $display("[voxel_face_culling] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
